// ----- src/assert_macros.svh -----
// Assertion helpers for the matcher sources.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset has been released.
`define BDNM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bdnm assertion failed");

// Checked on every rising edge, also while reset is held.
`define BDNM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bdnm assertion failed");

`endif

// ----- src/bdnm_pkg.sv -----
// ----------------------------------------------------------------------------
// bdnm_pkg
// Shared types, constants and the 32-bit population count of the matcher.
// ----------------------------------------------------------------------------
package bdnm_pkg;

    localparam int ENTRIES      = 1024;
    localparam int DESC_WORDS32 = 8;

    localparam int DESC_W    = 256;
    localparam int WORDS32   = DESC_W / 32;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int DIST_W    = 9;
    localparam int LIMIT_W   = 9;
    localparam int IDX_OUT_W = 10;
    localparam int POP_W     = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd100;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [31:0] M1 = 32'h5555_5555;
    localparam logic [31:0] M2 = 32'h3333_3333;
    localparam logic [31:0] M4 = 32'h0F0F_0F0F;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
    } dist_res_t;

    function automatic logic [POP_W-1:0] popcount32(input logic [31:0] x);
        logic [31:0] v;
        logic [POP_W-1:0] s;
        v = x - ((x >> 1) & M1);
        v = (v & M2) + ((v >> 2) & M2);
        v = (v + (v >> 4)) & M4;
        s = POP_W'(v[7:0]) + POP_W'(v[15:8]) + POP_W'(v[23:16]) + POP_W'(v[31:24]);
        return s;
    endfunction

endpackage

// ----- src/binary_descriptor_nearest_match.sv -----
// ----------------------------------------------------------------------------
// binary_descriptor_nearest_match
// Brute-force Hamming matcher for 256-bit binary descriptors over a table
// held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage: the input channel (s_valid/s_ready) carries one beat per item with a
// kind and four 64-bit descriptor words. Kind 0 empties the table, kind 1
// appends the descriptor at the next free slot, kind 2 queries it against all
// stored entries, kind 3 does nothing. Every beat yields exactly one result
// beat on the m_ channel (found, best_index, best_distance, table_full).
// Clear, load and ignored items, and queries on an empty table, go from
// acceptance straight to the done state, which loads the result register. A
// query over N stored entries passes the scan, drain and done states: the
// scan reads one table entry per cycle through the single RAM read port, the
// drain waits until the read and distance pipeline is empty, and done loads
// the result register. The user must write the distance limit through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// The limit resets to 100. Reset empties the table (entry count zero) without
// touching the RAM. A stalled receiver holds the result register; one more item
// is accepted meanwhile and waits with its finished result until it frees up.
module binary_descriptor_nearest_match (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [63:0] s_desc_word0,
    input  logic [63:0] s_desc_word1,
    input  logic [63:0] s_desc_word2,
    input  logic [63:0] s_desc_word3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [9:0]  m_best_index,
    output logic [8:0]  m_best_distance,
    output logic        m_table_full
);
    import bdnm_pkg::*;

    `include "assert_macros.svh"

    state_t state_reg, state_next;

    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [DESC_W-1:0]  qry_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;

    // Result being assembled for the current item.
    logic               res_found_reg;
    logic [IDX_W-1:0]   res_idx_reg;
    logic [DIST_W-1:0]  res_dist_reg;
    logic               res_full_reg;
    logic [LIMIT_W-1:0] best_reg;

    // Output register.
    logic               m_valid_reg;
    logic               m_found_reg;
    logic [IDX_OUT_W-1:0] m_best_index_reg;
    logic [DIST_W-1:0]  m_best_distance_reg;
    logic               m_table_full_reg;

    logic               accept;
    logic               ram_re;
    logic               ram_we;
    logic               out_load;
    logic               last_issue;
    logic               pipe_busy;
    logic               table_has_room;
    logic [DESC_W-1:0]  in_desc;
    logic [DESC_W-1:0]  ram_q;
    dist_res_t          dres;

    assign in_desc        = {s_desc_word3, s_desc_word2, s_desc_word1, s_desc_word0};
    assign accept         = s_valid && s_ready;
    assign table_has_room = (count_reg < CNT_W'(ENTRIES));
    assign last_issue     = (scan_idx_reg == IDX_W'(count_reg - CNT_W'(1)));
    assign pipe_busy      = rd_vld_reg || dres.valid;

    // Descriptor table: written at the fill point, read sequentially by a scan.
    bdnm_ram #(
        .WIDTH (DESC_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (IDX_W'(count_reg)),
        .wdata (in_desc),
        .re    (ram_re),
        .raddr (scan_idx_reg),
        .rdata (ram_q)
    );

    bdnm_dist u_dist (
        .clk      (aclk),
        .rst_n    (aresetn),
        .in_valid (rd_vld_reg),
        .in_idx   (rd_idx_reg),
        .ref_desc (ram_q),
        .qry_desc (qry_reg),
        .res      (dres)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_QUERY && count_reg != '0) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (last_issue) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_ready  = 1'b0;
        ram_re   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE:  s_ready  = 1'b1;
            S_SCAN:  ram_re   = 1'b1;
            S_DRAIN: ;
            S_DONE:  out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // A load that finds the table full is dropped and only flagged.
    assign ram_we = accept && (s_kind == KIND_LOAD) && table_has_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            limit_reg    <= LIMIT_RESET;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= ram_re;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (accept && s_kind == KIND_CLEAR) begin
                count_reg <= '0;
            end else if (ram_we) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (accept) begin
                scan_idx_reg <= '0;
            end else if (ram_re) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: query, scan tags and result.
    always_ff @(posedge aclk) begin
        rd_idx_reg <= scan_idx_reg;
        if (accept) begin
            qry_reg       <= in_desc;
            best_reg      <= limit_reg;
            res_found_reg <= 1'b0;
            res_idx_reg   <= '0;
            res_dist_reg  <= '0;
            res_full_reg  <= (s_kind == KIND_LOAD) && !table_has_room;
        end else if (dres.valid && (LIMIT_W'(dres.distance) < best_reg)) begin
            // Strict compare keeps the first occurrence of the minimum.
            best_reg      <= LIMIT_W'(dres.distance);
            res_found_reg <= 1'b1;
            res_idx_reg   <= dres.idx;
            res_dist_reg  <= dres.distance;
        end
        if (out_load) begin
            m_found_reg         <= res_found_reg;
            m_best_index_reg    <= IDX_OUT_W'(res_idx_reg);
            m_best_distance_reg <= res_dist_reg;
            m_table_full_reg    <= res_full_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_best_index    = m_best_index_reg;
    assign m_best_distance = m_best_distance_reg;
    assign m_table_full    = m_table_full_reg;

    `BDNM_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(ENTRIES))
    `BDNM_ASSERT(a_scan_in_range, aclk, aresetn,
        (state_reg == S_SCAN) |-> (CNT_W'(scan_idx_reg) < count_reg))
    `BDNM_ASSERT(a_dist_only_scan, aclk, aresetn,
        dres.valid |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
    `BDNM_ASSERT(a_found_below_limit, aclk, aresetn,
        (m_valid_reg && m_found_reg) |-> (LIMIT_W'(m_best_distance_reg) < limit_reg))

endmodule

// ----- src/bdnm_ram.sv -----
// ----------------------------------------------------------------------------
// bdnm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bdnm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bdnm_dist.sv -----
// ----------------------------------------------------------------------------
// bdnm_dist
// Two-stage Hamming distance unit: per-word counts, then the summing tree.
// ----------------------------------------------------------------------------
module bdnm_dist (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    input  logic [bdnm_pkg::IDX_W-1:0]                 in_idx,
    input  logic [bdnm_pkg::DESC_W-1:0]                ref_desc,
    input  logic [bdnm_pkg::DESC_W-1:0]                qry_desc,
    output bdnm_pkg::dist_res_t                        res
);
    import bdnm_pkg::*;

    logic [POP_W-1:0]  cnt_next [WORDS32];
    logic [POP_W-1:0]  cnt_reg  [WORDS32];
    logic              vld_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DIST_W-1:0] sum;

    // Words past the configured descriptor length do not count.
    always_comb begin
        for (int w = 0; w < WORDS32; w++) begin
            if (w < DESC_WORDS32) begin
                cnt_next[w] = popcount32(ref_desc[w*32 +: 32] ^ qry_desc[w*32 +: 32]);
            end else begin
                cnt_next[w] = '0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= in_valid;
        end
        idx_reg <= in_idx;
        for (int w = 0; w < WORDS32; w++) begin
            cnt_reg[w] <= cnt_next[w];
        end
    end

    always_comb begin
        sum = '0;
        for (int w = 0; w < WORDS32; w++) begin
            sum = sum + DIST_W'(cnt_reg[w]);
        end
    end

    assign res.valid    = vld_reg;
    assign res.idx      = idx_reg;
    assign res.distance = sum;

endmodule
